// ===== hw/rtl/his_pkg.sv =====
// ----------------------------------------------------------------------------
// his_pkg
// Shared types and constants for the homography inlier scoring block.
// ----------------------------------------------------------------------------
package his_pkg;

  localparam int COORD_W    = 24;
  localparam int COEF_W     = 32;
  localparam int PROD_W     = COORD_W + COEF_W;   // one coefficient times one coordinate
  localparam int ACC_W      = PROD_W + 2;         // sum of two products and a constant
  localparam int FRAC_BITS  = 9;                  // eight result fraction bits plus a rounding bit
  localparam int DIVD_W     = ACC_W + FRAC_BITS;  // dividend width, numerator shifted up
  localparam int DIV_CNT_W  = 7;
  localparam int QMAG_W     = 49;                 // rounded quotient magnitude, up to 2^48
  localparam int ERR_W      = 48;
  localparam int TALLY_W    = 13;
  localparam int MAX_POINTS = 4096;
  localparam int TALLY_CAP  = (MAX_POINTS < 8191) ? MAX_POINTS : 8191;
  localparam int CFG_W      = 64;
  localparam int CFG_IDX_W  = 3;
  localparam int DIST_W     = 24;

  localparam logic [ERR_W-1:0] ERR_MAX = {ERR_W{1'b1}};
  localparam logic [ACC_W-1:0] W_ONE   = ACC_W'(64'd1 << 24);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COEF_H0_H1     = 3'd0,
    CFG_COEF_H2_H3     = 3'd1,
    CFG_COEF_H4_H5     = 3'd2,
    CFG_COEF_H6_H7     = 3'd3,
    CFG_INLIER_DISTANCE = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] h0;
    logic signed [COEF_W-1:0] h1;
    logic signed [COEF_W-1:0] h2;
    logic signed [COEF_W-1:0] h3;
    logic signed [COEF_W-1:0] h4;
    logic signed [COEF_W-1:0] h5;
    logic signed [COEF_W-1:0] h6;
    logic signed [COEF_W-1:0] h7;
  } coef_t;

  // projected sums of one correspondence, handed from front to back
  typedef struct packed {
    logic signed [ACC_W-1:0]   nu;
    logic signed [ACC_W-1:0]   nv;
    logic signed [ACC_W-1:0]   w;
    logic signed [COORD_W-1:0] img_x;
    logic signed [COORD_W-1:0] img_y;
    logic                      last_pair;
  } proj_t;

  typedef struct packed {
    logic [ERR_W-1:0]   sq_error;
    logic               is_inlier;
    logic [TALLY_W-1:0] inlier_total;
    logic               degenerate_map;
    logic               set_done;
  } result_t;

endpackage

// ===== hw/rtl/his_front.sv =====
// ----------------------------------------------------------------------------
// his_front
// Takes one correspondence and forms w, nu and nv with one shared multiplier.
// ----------------------------------------------------------------------------
module his_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  his_pkg::coef_t                   coef,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [his_pkg::COORD_W-1:0] obj_x,
  input  logic signed [his_pkg::COORD_W-1:0] obj_y,
  input  logic signed [his_pkg::COORD_W-1:0] img_x,
  input  logic signed [his_pkg::COORD_W-1:0] img_y,
  input  logic                             last_pair,
  output logic                             push_valid,
  input  logic                             push_ready,
  output his_pkg::proj_t                   push_data
);

  localparam logic [2:0] STEP_PUSH = 3'd7;
  localparam logic [2:0] STEP_LAST_MUL = 3'd5;

  logic                              busy_r, busy_nxt;
  logic [2:0]                        step_r, step_nxt;
  logic signed [his_pkg::COORD_W-1:0] x_r, y_r, ix_r, iy_r;
  logic                              last_r;
  logic signed [his_pkg::PROD_W-1:0] prod_r, prod_nxt;
  logic signed [his_pkg::ACC_W-1:0]  w_r, nu_r, nv_r;
  logic signed [his_pkg::COEF_W-1:0] mul_a;
  logic signed [his_pkg::COORD_W-1:0] mul_b;
  logic signed [his_pkg::ACC_W-1:0]  prod_ext;
  logic                              accept;

  assign in_ready   = !busy_r;
  assign accept     = in_valid && in_ready;
  assign push_valid = busy_r && (step_r == STEP_PUSH);
  assign prod_ext   = his_pkg::ACC_W'(prod_r);

  // operand order: w terms, then nu terms, then nv terms
  always_comb begin
    case (step_r)
      3'd0: begin mul_a = coef.h6; mul_b = x_r; end
      3'd1: begin mul_a = coef.h7; mul_b = y_r; end
      3'd2: begin mul_a = coef.h0; mul_b = x_r; end
      3'd3: begin mul_a = coef.h1; mul_b = y_r; end
      3'd4: begin mul_a = coef.h3; mul_b = x_r; end
      3'd5: begin mul_a = coef.h4; mul_b = y_r; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
    prod_nxt = his_pkg::PROD_W'(mul_a * mul_b);
  end

  always_comb begin
    busy_nxt = busy_r;
    step_nxt = step_r;
    if (accept) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
    end else if (busy_r) begin
      if (step_r == STEP_PUSH) begin
        if (push_ready) busy_nxt = 1'b0;
      end else begin
        step_nxt = step_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      x_r    <= obj_x;
      y_r    <= obj_y;
      ix_r   <= img_x;
      iy_r   <= img_y;
      last_r <= last_pair;
      w_r    <= his_pkg::W_ONE;
      nu_r   <= his_pkg::ACC_W'(coef.h2) <<< 8;
      nv_r   <= his_pkg::ACC_W'(coef.h5) <<< 8;
    end else if (busy_r && step_r != STEP_PUSH) begin
      if (step_r <= STEP_LAST_MUL) prod_r <= prod_nxt;
      case (step_r)
        3'd1, 3'd2: w_r  <= w_r + prod_ext;
        3'd3, 3'd4: nu_r <= nu_r + prod_ext;
        3'd5, 3'd6: nv_r <= nv_r + prod_ext;
        default: ;
      endcase
    end
  end

  always_comb begin
    push_data.nu        = nu_r;
    push_data.nv        = nv_r;
    push_data.w         = w_r;
    push_data.img_x     = ix_r;
    push_data.img_y     = iy_r;
    push_data.last_pair = last_r;
  end

endmodule

// ===== hw/rtl/his_queue.sv =====
// ----------------------------------------------------------------------------
// his_queue
// Two-entry queue between the projection front and the scoring back.
// ----------------------------------------------------------------------------
module his_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  his_pkg::proj_t push_data,
  output logic           pop_valid,
  input  logic           pop_ready,
  output his_pkg::proj_t pop_data
);

  his_pkg::proj_t store_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;
  logic       do_push, do_pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_data   = store_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= !wr_ptr_r;
      if (do_pop)  rd_ptr_r <= !rd_ptr_r;
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) store_r[wr_ptr_r] <= push_data;
  end

endmodule

// ===== hw/rtl/his_back.sv =====
// ----------------------------------------------------------------------------
// his_back
// Divides by w bit-serially, forms the squared error and keeps the tally.
// ----------------------------------------------------------------------------
module his_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [his_pkg::DIST_W-1:0]      inlier_distance,
  input  logic                            pop_valid,
  output logic                            pop_ready,
  input  his_pkg::proj_t                  pop_data,
  output logic                            res_valid,
  input  logic                            res_ready,
  output his_pkg::result_t                res_data
);

  localparam int MAG_W = his_pkg::ACC_W;
  localparam int REM_W = MAG_W + 1;
  localparam int DW    = his_pkg::DIVD_W;
  localparam int QW    = his_pkg::QMAG_W;

  typedef enum logic [2:0] {S_IDLE, S_DIV, S_FIX, S_SQ, S_SUM, S_FIN} state_t;

  state_t                        state_r;
  logic [his_pkg::DIV_CNT_W-1:0] cnt_r;
  logic [DW-1:0]                 nu_sh_r, nv_sh_r, qu_r, qv_r;
  logic [REM_W-1:0]              ru_r, rv_r;
  logic [MAG_W-1:0]              d_r;
  logic                          neg_u_r, neg_v_r, degen_r, last_r, sat_r;
  logic signed [his_pkg::COORD_W-1:0] ix_r, iy_r;
  logic [his_pkg::COORD_W-1:0]   au_r, av_r;
  logic [his_pkg::ERR_W-1:0]     squ_r, sqv_r, t2_r, err_r;
  logic [his_pkg::TALLY_W-1:0]   tally_r;
  logic                          res_valid_r;
  his_pkg::result_t              res_r;

  logic [MAG_W-1:0]              mag_nu, mag_nv, mag_w;
  logic [REM_W-1:0]              ru_t, rv_t;
  logic                          ge_u, ge_v;
  logic [QW:0]                   qm_u, qm_v;
  logic signed [QW+1:0]          u_s, v_s;
  logic signed [QW+2:0]          du, dv;
  logic                          sat_u, sat_v;
  logic [his_pkg::ERR_W:0]       sum_sq;
  logic                          out_free, inl;
  logic [his_pkg::TALLY_W-1:0]   tally_inc;

  function automatic logic [MAG_W-1:0] mag(input logic signed [MAG_W-1:0] v);
    mag = v[MAG_W-1] ? MAG_W'(-v) : MAG_W'(v);
  endfunction

  function automatic logic [QW:0] round_q(input logic [DW-1:0] q);
    if (q[DW-1:QW] != '0) round_q = (QW+1)'(1) << (QW - 1);
    else                  round_q = ((QW+1)'(q[QW-1:0]) + (QW+1)'(1)) >> 1;
  endfunction

  assign mag_nu = mag(pop_data.nu);
  assign mag_nv = mag(pop_data.nv);
  assign mag_w  = mag(pop_data.w);

  assign ru_t = {ru_r[MAG_W-1:0], nu_sh_r[DW-1]};
  assign rv_t = {rv_r[MAG_W-1:0], nv_sh_r[DW-1]};
  assign ge_u = ru_t >= REM_W'(d_r);
  assign ge_v = rv_t >= REM_W'(d_r);

  assign qm_u = round_q(qu_r);
  assign qm_v = round_q(qv_r);
  assign u_s  = neg_u_r ? -$signed({1'b0, qm_u}) : $signed({1'b0, qm_u});
  assign v_s  = neg_v_r ? -$signed({1'b0, qm_v}) : $signed({1'b0, qm_v});
  assign du   = (QW+3)'(u_s) - (QW+3)'(ix_r);
  assign dv   = (QW+3)'(v_s) - (QW+3)'(iy_r);
  assign sat_u = (du >= (QW+3)'(64'sd16777216)) || (du <= -(QW+3)'(64'sd16777216));
  assign sat_v = (dv >= (QW+3)'(64'sd16777216)) || (dv <= -(QW+3)'(64'sd16777216));

  assign sum_sq    = (his_pkg::ERR_W+1)'(squ_r) + (his_pkg::ERR_W+1)'(sqv_r);
  assign out_free  = !res_valid_r || res_ready;
  assign inl       = !degen_r && (err_r < t2_r);
  assign tally_inc = (inl && tally_r < his_pkg::TALLY_W'(his_pkg::TALLY_CAP))
                     ? tally_r + his_pkg::TALLY_W'(1) : tally_r;

  assign pop_ready = (state_r == S_IDLE);
  assign res_valid = res_valid_r;
  assign res_data  = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      tally_r     <= '0;
      res_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      // in the output state a taken result is replaced by the next one
      if (res_valid_r && res_ready && state_r != S_FIN) res_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (pop_valid) begin
            nu_sh_r <= {mag_nu, his_pkg::FRAC_BITS'(0)};
            nv_sh_r <= {mag_nv, his_pkg::FRAC_BITS'(0)};
            d_r     <= mag_w;
            ru_r    <= '0;
            rv_r    <= '0;
            qu_r    <= '0;
            qv_r    <= '0;
            neg_u_r <= pop_data.nu[MAG_W-1] ^ pop_data.w[MAG_W-1];
            neg_v_r <= pop_data.nv[MAG_W-1] ^ pop_data.w[MAG_W-1];
            ix_r    <= pop_data.img_x;
            iy_r    <= pop_data.img_y;
            last_r  <= pop_data.last_pair;
            degen_r <= (pop_data.w == '0);
            cnt_r   <= his_pkg::DIV_CNT_W'(DW - 1);
            if (pop_data.w == '0) begin
              err_r   <= his_pkg::ERR_MAX;
              state_r <= S_FIN;
            end else begin
              state_r <= S_DIV;
            end
          end
        end
        S_DIV: begin
          nu_sh_r <= nu_sh_r << 1;
          nv_sh_r <= nv_sh_r << 1;
          ru_r    <= ge_u ? ru_t - REM_W'(d_r) : ru_t;
          rv_r    <= ge_v ? rv_t - REM_W'(d_r) : rv_t;
          qu_r    <= {qu_r[DW-2:0], ge_u};
          qv_r    <= {qv_r[DW-2:0], ge_v};
          cnt_r   <= cnt_r - his_pkg::DIV_CNT_W'(1);
          if (cnt_r == '0) state_r <= S_FIX;
        end
        S_FIX: begin
          sat_r   <= sat_u || sat_v;
          au_r    <= his_pkg::COORD_W'(du[QW+2] ? -du : du);
          av_r    <= his_pkg::COORD_W'(dv[QW+2] ? -dv : dv);
          state_r <= S_SQ;
        end
        S_SQ: begin
          squ_r   <= au_r * au_r;
          sqv_r   <= av_r * av_r;
          t2_r    <= inlier_distance * inlier_distance;
          state_r <= S_SUM;
        end
        S_SUM: begin
          err_r   <= (sat_r || sum_sq[his_pkg::ERR_W]) ? his_pkg::ERR_MAX
                     : sum_sq[his_pkg::ERR_W-1:0];
          state_r <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            res_valid_r        <= 1'b1;
            res_r.sq_error       <= err_r;
            res_r.is_inlier      <= inl;
            res_r.inlier_total   <= tally_inc;
            res_r.degenerate_map <= degen_r;
            res_r.set_done       <= last_r;
            tally_r            <= last_r ? '0 : tally_inc;
            state_r            <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // a degenerate map is never an inlier and reports a saturated error
  a_degen_not_inlier: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid_r && res_r.degenerate_map |-> !res_r.is_inlier
      && res_r.sq_error == his_pkg::ERR_MAX)
    else $error("degenerate result flagged as inlier");

  a_tally_cap: assert property (@(posedge clk) disable iff (!rst_n)
    tally_r <= his_pkg::TALLY_W'(his_pkg::TALLY_CAP))
    else $error("inlier tally above cap");

  // tally is cleared once a set-closing result has been produced
  a_tally_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FIN && out_free && last_r |=> tally_r == '0)
    else $error("tally not cleared after last pair");

endmodule

// ===== hw/rtl/homography_inlier_scoring.sv =====
// ----------------------------------------------------------------------------
// homography_inlier_scoring
// Scores point correspondences against one configured homography.
// ----------------------------------------------------------------------------
// Each transfer on the in_ side brings one object/image point pair; each
// pair gives exactly one result on the out_ side carrying the squared
// reprojection error, the inlier flag and the running inlier count, which
// is final on the result marked by out_tlast and clears after it. The
// front shares one 32x24 multiplier over the six coefficient products,
// then hands the pair off to the queue; the back loads it, divides
// bit-serially by the projective denominator, then does rounding,
// squaring and summing, and registers the result. The back is busy
// longer per pair than the front and sets the sustained rate. A two-entry
// queue lets the front project the next pair while the back divides. A
// zero denominator skips the divide and gives a saturated, flagged
// non-inlier. A held-off out_tready keeps the back in its output state
// while a result waits. Coefficients and threshold come from the cfg_
// port and are to be written by the user only while idle; the block
// does not enforce it.
module homography_inlier_scoring (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [his_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [his_pkg::CFG_W-1:0]      cfg_wdata,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [95:0]                    in_tdata,   // obj_x, obj_y, img_x, img_y
  input  logic                           in_tlast,   // last_pair
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [63:0]                    out_tdata,  // sq_error, is_inlier, inlier_total, degenerate_map, zero pad
  output logic                           out_tlast   // set_done
);

  // configuration registers
  logic [his_pkg::CFG_W-1:0]  h01_r, h23_r, h45_r, h67_r;
  logic [his_pkg::DIST_W-1:0] dist_r;
  his_pkg::coef_t             coef;

  // front to queue, queue to back
  logic             push_valid, push_ready, pop_valid, pop_ready;
  his_pkg::proj_t   push_data, pop_data;
  logic             res_valid;
  his_pkg::result_t res_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h01_r  <= 64'h0001_0000_0000_0000;
      h23_r  <= '0;
      h45_r  <= 64'h0001_0000_0000_0000;
      h67_r  <= '0;
      dist_r <= his_pkg::DIST_W'(768);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        his_pkg::CFG_COEF_H0_H1:      h01_r  <= cfg_wdata;
        his_pkg::CFG_COEF_H2_H3:      h23_r  <= cfg_wdata;
        his_pkg::CFG_COEF_H4_H5:      h45_r  <= cfg_wdata;
        his_pkg::CFG_COEF_H6_H7:      h67_r  <= cfg_wdata;
        his_pkg::CFG_INLIER_DISTANCE: dist_r <= cfg_wdata[his_pkg::DIST_W-1:0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  always_comb begin
    coef.h0 = h01_r[63:32];
    coef.h1 = h01_r[31:0];
    coef.h2 = h23_r[63:32];
    coef.h3 = h23_r[31:0];
    coef.h4 = h45_r[63:32];
    coef.h5 = h45_r[31:0];
    coef.h6 = h67_r[63:32];
    coef.h7 = h67_r[31:0];
  end

  his_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .coef       (coef),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .obj_x      (in_tdata[23:0]),
    .obj_y      (in_tdata[47:24]),
    .img_x      (in_tdata[71:48]),
    .img_y      (in_tdata[95:72]),
    .last_pair  (in_tlast),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  his_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  his_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .inlier_distance (dist_r),
    .pop_valid       (pop_valid),
    .pop_ready       (pop_ready),
    .pop_data        (pop_data),
    .res_valid       (res_valid),
    .res_ready       (out_tready),
    .res_data        (res_data)
  );

  // result register lives in the back; pack it onto the stream
  assign out_tvalid = res_valid;
  assign out_tdata  = {1'b0, res_data.degenerate_map, res_data.inlier_total,
                       res_data.is_inlier, res_data.sq_error};
  assign out_tlast  = res_data.set_done;

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// homography inlier scoring testbench
// Streams point pairs through the scorer under several homographies and
// thresholds, predicts each squared error, inlier flag and running count,
// and compares every result transfer against the predicted queue.
// ----------------------------------------------------------------------------
module testbench;

  localparam int LAT = 200;

  typedef struct packed {
    logic [47:0] sq_error;
    logic        is_inlier;
    logic [12:0] inlier_total;
    logic        degenerate_map;
    logic        set_done;
  } score_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_wdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [95:0] in_tdata = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic        out_tlast;

  // predictor copy of the configuration and the tally
  logic [63:0] m_h01, m_h23, m_h45, m_h67;
  logic [23:0] m_dist;
  int unsigned m_tally;

  score_t score_q[$];
  int     errors = 0;
  int     n_pairs = 0;
  int     n_results = 0;
  int     inlier_seen = 0;
  int     n_degen = 0;
  int     n_sat = 0;
  bit     out_idle_bias = 1'b0;

  homography_inlier_scoring u_dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // generous fixed limit: ~1400 items at worst-case gaps and stalls, many times over
  initial begin
    #100ms;
    $display("TEST FAILED");
    $finish;
  end

  // random gap length, mostly short, sometimes long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(20, 150);
  endfunction

  // divide a Q.24 numerator by a Q.24 denominator to Q.8, round half away
  function automatic longint div_q8(longint num, longint den);
    logic [63:0] n, d, qi, r, q;
    bit neg;
    neg = (num < 0) != (den < 0);
    n = (num < 0) ? -num : num;
    d = (den < 0) ? -den : den;
    qi = n / d;
    r = n % d;
    if (qi >= (64'd1 << 40)) begin
      q = 64'd1 << 48;
    end else begin
      q = qi;
      for (int i = 0; i < 9; i++) begin
        r = r << 1;
        q = q << 1;
        if (r >= d) begin
          r = r - d;
          q[0] = 1'b1;
        end
      end
      q = (q + 1) >> 1;
    end
    return neg ? -longint'(q) : longint'(q);
  endfunction

  function automatic score_t score_pair(logic [23:0] ox, logic [23:0] oy,
                                        logic [23:0] ix, logic [23:0] iy, bit last);
    score_t s;
    longint x, y, jx, jy, w, nu, nv, du, dv;
    logic [63:0] err, t2, au, av;
    bit degen, inl;
    x = longint'(signed'(ox));
    y = longint'(signed'(oy));
    jx = longint'(signed'(ix));
    jy = longint'(signed'(iy));
    w  = longint'(signed'(m_h67[63:32])) * x + longint'(signed'(m_h67[31:0])) * y
         + (64'sd1 <<< 24);
    nu = longint'(signed'(m_h01[63:32])) * x + longint'(signed'(m_h01[31:0])) * y
         + longint'(signed'(m_h23[63:32])) * 256;
    nv = longint'(signed'(m_h23[31:0])) * x + longint'(signed'(m_h45[63:32])) * y
         + longint'(signed'(m_h45[31:0])) * 256;
    degen = (w == 0);
    if (degen) begin
      err = 64'hFFFF_FFFF_FFFF;
    end else begin
      du = div_q8(nu, w) - jx;
      dv = div_q8(nv, w) - jy;
      if (du <= -(64'sd1 <<< 24) || du >= (64'sd1 <<< 24) ||
          dv <= -(64'sd1 <<< 24) || dv >= (64'sd1 <<< 24)) begin
        err = 64'hFFFF_FFFF_FFFF;
      end else begin
        au = (du < 0) ? -du : du;
        av = (dv < 0) ? -dv : dv;
        err = au * au + av * av;
        if (err > 64'hFFFF_FFFF_FFFF) err = 64'hFFFF_FFFF_FFFF;
      end
    end
    t2 = 64'(m_dist) * 64'(m_dist);
    inl = !degen && err < t2;
    if (inl && m_tally < his_pkg::TALLY_CAP) m_tally++;
    s.sq_error = err[47:0];
    s.is_inlier = inl;
    s.inlier_total = m_tally[12:0];
    s.degenerate_map = degen;
    s.set_done = last;
    if (last) m_tally = 0;
    return s;
  endfunction

  // write enable stays high across back-to-back writes
  task automatic write_reg(his_pkg::cfg_idx_t idx, logic [63:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      his_pkg::CFG_COEF_H0_H1:      m_h01 = val;
      his_pkg::CFG_COEF_H2_H3:      m_h23 = val;
      his_pkg::CFG_COEF_H4_H5:      m_h45 = val;
      his_pkg::CFG_COEF_H6_H7:      m_h67 = val;
      his_pkg::CFG_INLIER_DISTANCE: m_dist = val[23:0];
      default: ;
    endcase
  endtask

  task automatic set_homography(logic [31:0] h0, h1, h2, h3, h4, h5, h6, h7,
                                logic [23:0] thr);
    write_reg(his_pkg::CFG_COEF_H0_H1, {h0, h1});
    write_reg(his_pkg::CFG_COEF_H2_H3, {h2, h3});
    write_reg(his_pkg::CFG_COEF_H4_H5, {h4, h5});
    write_reg(his_pkg::CFG_COEF_H6_H7, {h6, h7});
    write_reg(his_pkg::CFG_INLIER_DISTANCE, 64'(thr));
    cfg_wr_en <= 1'b0;
  endtask

  // send one pair; predicted score is queued at the accepting edge
  task automatic send_pair(logic [23:0] ox, oy, ix, iy, bit last);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {iy, ix, oy, ox};
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    score_q.push_back(score_pair(ox, oy, ix, iy, last));
    n_pairs++;
  endtask

  // wait until every expected result transfer has come, then a latency pause
  task automatic drain();
    in_tvalid <= 1'b0;
    while (score_q.size() != 0) @(posedge clk);
    repeat (LAT) @(posedge clk);
  endtask

  // result receiver with random stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= out_idle_bias ? 1'b1 : ($urandom_range(0, 9) < 7);
    end
  end

  // result checker
  always @(posedge clk) begin
    score_t got, exp_s;
    if (rst_n && out_tvalid && out_tready) begin
      got.sq_error = out_tdata[47:0];
      got.is_inlier = out_tdata[48];
      got.inlier_total = out_tdata[61:49];
      got.degenerate_map = out_tdata[62];
      got.set_done = out_tlast;
      n_results++;
      if (score_q.size() == 0) begin
        $error("result transfer with nothing expected: tdata=%h", out_tdata);
        errors++;
      end else begin
        exp_s = score_q.pop_front();
        if (got.is_inlier) inlier_seen++;
        if (got.degenerate_map) n_degen++;
        if (got.sq_error == his_pkg::ERR_MAX) n_sat++;
        if (got.sq_error !== exp_s.sq_error) begin
          $error("sq_error expected %h got %h", exp_s.sq_error, got.sq_error);
          errors++;
        end
        if (got.is_inlier !== exp_s.is_inlier) begin
          $error("is_inlier expected %0d got %0d", exp_s.is_inlier, got.is_inlier);
          errors++;
        end
        if (got.inlier_total !== exp_s.inlier_total) begin
          $error("inlier_total expected %0d got %0d", exp_s.inlier_total,
                 got.inlier_total);
          errors++;
        end
        if (got.degenerate_map !== exp_s.degenerate_map) begin
          $error("degenerate_map expected %0d got %0d", exp_s.degenerate_map,
                 got.degenerate_map);
          errors++;
        end
        if (got.set_done !== exp_s.set_done) begin
          $error("set_done expected %0d got %0d", exp_s.set_done, got.set_done);
          errors++;
        end
      end
    end
  end

  function automatic logic [23:0] rnd24();
    return 24'($urandom);
  endfunction

  // small coordinate near the origin, used so points land near their match
  function automatic logic [23:0] near(int span);
    return 24'($urandom_range(0, 2 * span) - span);
  endfunction

  // directed: reset coefficients, field extremes, degenerate and saturated cases
  task automatic test_directed();
    send_pair(24'h000100, 24'h000200, 24'h000100, 24'h000200, 1'b0); // exact inlier
    send_pair(24'h000100, 24'h000200, 24'h000400, 24'h000200, 1'b0); // error 3px, edge
    send_pair(24'h000100, 24'h000200, 24'h0003FF, 24'h000200, 1'b0);
    send_pair(24'h7FFFFF, 24'h7FFFFF, 24'h800000, 24'h800000, 1'b0); // saturated error
    send_pair(24'h800000, 24'h800000, 24'h800000, 24'h800000, 1'b0);
    send_pair(24'h800000, 24'h7FFFFF, 24'h7FFFFF, 24'h800000, 1'b1);
    send_pair(24'h000000, 24'h000000, 24'h000000, 24'h000000, 1'b1); // one-item set
    drain();
    // h6 = -1.0: denominator zero at x = 1.0
    set_homography(32'h0001_0000, 32'h0, 32'h0, 32'h0, 32'h0001_0000, 32'h0,
                   32'hFFFF_0000, 32'h0, 24'hFFFFFF);
    send_pair(24'h000100, 24'h000500, 24'h0, 24'h0, 1'b0);            // degenerate
    send_pair(24'h000180, 24'h000100, 24'h0, 24'h0, 1'b0);
    send_pair(24'h0000FF, 24'h000000, 24'h0, 24'h0, 1'b0);            // tiny w, huge quotient
    send_pair(24'h000101, 24'h000000, 24'h0, 24'h0, 1'b1);
    drain();
    // all-ones and extreme coefficients, zero threshold
    set_homography(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                   32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF, 24'h0);
    send_pair(24'h000001, 24'hFFFFFF, 24'h0, 24'h0, 1'b0);
    send_pair(24'h7FFFFF, 24'h000001, 24'h7FFFFF, 24'h7FFFFF, 1'b0);
    send_pair(24'h000000, 24'h000000, 24'h7FFFFF, 24'h800000, 1'b1);
    drain();
  endtask

  // random point sets: mostly image points near their object point, some noise
  task automatic test_random_sets(int n_items, int span);
    int left, sz;
    logic [23:0] ox, oy;
    left = n_items;
    while (left > 0) begin
      sz = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 120) : $urandom_range(1, 12);
      for (int i = 0; i < sz && left > 0; i++, left--) begin
        ox = near(span);
        oy = near(span);
        if ($urandom_range(0, 9) < 7) begin
          // near match: identity-ish image point with small offset
          send_pair(ox, oy, ox + near(4 * 256), oy + near(4 * 256), i == sz - 1);
        end else begin
          send_pair(rnd24(), rnd24(), rnd24(), rnd24(), i == sz - 1);
        end
      end
    end
    drain();
  endtask

  // one long set of exact matches, so the tally climbs high before clearing
  task automatic test_long_set();
    set_homography(32'h0001_0000, 32'h0, 32'h0, 32'h0, 32'h0001_0000, 32'h0,
                   32'h0, 32'h0, 24'hFFFFFF);
    out_idle_bias = 1'b1;
    for (int i = 0; i < 500; i++)
      send_pair(24'h0, 24'h0, 24'h0, 24'h0, i == 499);
    out_idle_bias = 1'b0;
    drain();
  endtask

  initial begin
    m_h01 = 64'h0001_0000_0000_0000;
    m_h23 = '0;
    m_h45 = 64'h0001_0000_0000_0000;
    m_h67 = '0;
    m_dist = 24'd768;
    m_tally = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    repeat (LAT) @(posedge clk);

    test_directed();
    // identity with shift, default-like threshold
    set_homography(32'h0001_0000, 32'h0, 32'h0002_8000, 32'h0, 32'h0001_0000,
                   32'hFFFE_0000, 32'h0, 32'h0, 24'd768);
    test_random_sets(250, 8 * 256);
    // mild perspective, larger threshold
    set_homography(32'h0001_0200, 32'hFFFF_FF00, 32'h0, 32'h0000_0100, 32'h0000_FE00,
                   32'h0, 32'h0000_0008, 32'hFFFF_FFF8, 24'd2560);
    test_random_sets(250, 64 * 256);
    // fully random coefficients and threshold
    set_homography($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                   $urandom, $urandom, rnd24());
    test_random_sets(200, 24'h7FFFFF);
    // random small perspective terms
    set_homography(32'h0001_0000 + near(4096), near(4096), $urandom, near(4096),
                   32'h0001_0000 + near(4096), $urandom, near(64), near(64), 24'd4096);
    test_random_sets(200, 16 * 256);
    test_long_set();

    $display("covered %0d pairs, %0d results: %0d inliers, %0d degenerate, %0d saturated",
             n_pairs, n_results, inlier_seen, n_degen, n_sat);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
hw/rtl/his_pkg.sv
hw/rtl/his_front.sv
hw/rtl/his_queue.sv
hw/rtl/his_back.sv
hw/rtl/homography_inlier_scoring.sv
bench/testbench.sv
